### sv/csfw_pkg.sv
// shared constants, types and codes for the counting semaphore with fifo waiters
package csfw_pkg;

   localparam int MAX_WAITERS    = 16;
   localparam int THREAD_ID_BITS = 8;
   localparam int COUNT_BITS     = 16;

   localparam int PTR_BITS    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int NUM_BITS    = $clog2(MAX_WAITERS + 1);
   localparam int VALUE_BITS  = 17;
   localparam int CFG_BITS    = 16;
   localparam int TID_FIELD   = 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(MAX_WAITERS - 1);
   localparam logic [NUM_BITS-1:0] NUM_FULL = NUM_BITS'(MAX_WAITERS);

   // register index, taken from paddr[2]
   localparam logic REG_INITIAL_COUNT = 1'b0;

   localparam logic KIND_TAKE    = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_RELEASED = 3'd2,
      ST_HANDED   = 3'd3,
      ST_REFUSED  = 3'd4
   } status_type;

   typedef struct packed {
      logic                      wr_en;
      logic [PTR_BITS-1:0]       wr_addr;
      logic [THREAD_ID_BITS-1:0] wr_data;
      logic                      rd_en;
      logic [PTR_BITS-1:0]       rd_addr;
   } ram_req_type;

   typedef struct packed {
      status_type              status;
      logic                    woken;
      logic [VALUE_BITS-1:0]   value;
   } result_ctrl_type;

endpackage

### sv/counting_semaphore_fifo_waiters.sv
// top level of the counting semaphore with a fifo queue of waiting threads
//
// each request transaction is a take (tuser 0) or a release (tuser 1) from one
// thread and produces exactly one response transaction. a take is granted while
// units are left; otherwise the thread id is queued in a 16-entry waiter memory.
// a release with waiters hands its unit straight to the oldest waiter, whose id
// comes back as woken_thread; otherwise the count goes up. a take with the queue
// full, or a release with no waiters and the count at its maximum, is refused and
// changes nothing. value reports the count after the step, or minus the number
// of waiters when the count is zero. a request is decided in the cycle it is
// accepted (count and queue pointers live in flip-flops); the waiter memory's
// registered read sits in a second stage, then the response register. throughput
// is one transaction per cycle while the response channel does not stall.
// writing initial_count (address 0) loads the count and leaves the queue alone;
// write it only while no transaction is in flight. no clearing pass after reset.
module counting_semaphore_fifo_waiters (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] thread_id
   input  logic        req_tuser,   // [0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] woken_thread, [24:8] value, [31:25] zero
   output logic [3:0]  rsp_tuser,   // [2:0] status, [3] woken_valid
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [csfw_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [csfw_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [csfw_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic        csr_pready
);
   import csfw_pkg::*;

   logic                      accept;
   logic                      load_en;
   logic [CFG_BITS-1:0]       load_value;
   ram_req_type               ram_req;
   result_ctrl_type           result;
   logic [THREAD_ID_BITS-1:0] rd_data;

   // stage two: memory read in flight
   logic                      s2_valid_ff, s2_valid_in;
   result_ctrl_type           s2_res_ff;
   logic                      s2_advance;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic                      rsp_woken_ff;
   logic [TID_FIELD-1:0]      rsp_thread_ff;
   logic [VALUE_BITS-1:0]     rsp_value_ff;

   // stage two moves on when the response register is empty or being drained
   assign s2_advance = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s2_valid_ff || s2_advance;
   assign accept     = req_tvalid && req_tready;

   csfw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .load_en     (load_en),
      .load_value  (load_value)
   );

   csfw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_tuser),
      .thread_id  (req_tdata[THREAD_ID_BITS-1:0]),
      .load_en    (load_en),
      .load_value (load_value),
      .ram_req    (ram_req),
      .result     (result)
   );

   // read data is only reloaded on a handoff, so it holds while stage two stalls
   csfw_wait_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (accept) begin
         s2_valid_in = 1'b1;
      end else if (s2_advance) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_res_ff <= result;
      end
      if (s2_advance) begin
         rsp_status_ff <= s2_res_ff.status;
         rsp_woken_ff  <= s2_res_ff.woken;
         rsp_thread_ff <= s2_res_ff.woken ? TID_FIELD'(rd_data) : '0;
         rsp_value_ff  <= s2_res_ff.value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_value_ff, rsp_thread_ff};
   assign rsp_tuser  = {rsp_woken_ff, rsp_status_ff};

endmodule

### sv/csfw_wait_ram.sv
// waiter id memory: one write port, one read port with registered data
module csfw_wait_ram (
   input  logic                                clock,
   input  csfw_pkg::ram_req_type               ram_req,
   output logic [csfw_pkg::THREAD_ID_BITS-1:0] rd_data
);
   import csfw_pkg::*;

   logic [THREAD_ID_BITS-1:0] mem [MAX_WAITERS];
   logic [THREAD_ID_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/csfw_csr.sv
// apb register block holding initial_count
module csfw_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [csfw_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [csfw_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [csfw_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output logic                               load_en,
   output logic [csfw_pkg::CFG_BITS-1:0]      load_value
);
   import csfw_pkg::*;

   logic [CFG_BITS-1:0] initial_count_ff;
   logic [CFG_BITS-1:0] initial_count_in;
   logic                wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_INITIAL_COUNT);

   always_comb begin
      initial_count_in = initial_count_ff;
      if (wr_hit) begin
         initial_count_in = csr_pwdata[CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_count_ff <= '0;
      end else begin
         initial_count_ff <= initial_count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_INITIAL_COUNT) begin
         csr_prdata = CSR_DATA_BITS'(initial_count_ff);
      end
   end

   assign load_en    = wr_hit;
   assign load_value = csr_pwdata[CFG_BITS-1:0];

endmodule

### sv/csfw_ctrl.sv
// semaphore count and waiter queue pointers, decision per transaction
module csfw_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                kind,
   input  logic [csfw_pkg::THREAD_ID_BITS-1:0] thread_id,
   input  logic                                load_en,
   input  logic [csfw_pkg::CFG_BITS-1:0]       load_value,
   output csfw_pkg::ram_req_type               ram_req,
   output csfw_pkg::result_ctrl_type           result
);
   import csfw_pkg::*;

   logic [COUNT_BITS-1:0] count_ff,  count_in;
   logic [PTR_BITS-1:0]   head_ff,   head_in;
   logic [PTR_BITS-1:0]   tail_ff,   tail_in;
   logic [NUM_BITS-1:0]   number_ff, number_in;
   status_type            status;

   function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] idx);
      return (idx == PTR_LAST) ? '0 : idx + PTR_BITS'(1);
   endfunction

   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      number_in = number_ff;
      status    = ST_REFUSED;
      ram_req   = '0;
      ram_req.wr_addr = tail_ff;
      ram_req.wr_data = thread_id;
      ram_req.rd_addr = head_ff;

      if (kind == KIND_TAKE) begin
         if (count_ff != '0) begin
            count_in = count_ff - COUNT_BITS'(1);
            status   = ST_GRANTED;
         end else if (number_ff >= NUM_FULL) begin
            status   = ST_REFUSED;
         end else begin
            ram_req.wr_en = accept;
            tail_in   = advance(tail_ff);
            number_in = number_ff + NUM_BITS'(1);
            status    = ST_QUEUED;
         end
      end else begin
         if (number_ff != '0) begin
            ram_req.rd_en = accept;
            head_in   = advance(head_ff);
            number_in = number_ff - NUM_BITS'(1);
            status    = ST_HANDED;
         end else if (count_ff == '1) begin
            status    = ST_REFUSED;
         end else begin
            count_in  = count_ff + COUNT_BITS'(1);
            status    = ST_RELEASED;
         end
      end

      result.status = status;
      result.woken  = (status == ST_HANDED);
      if (count_in != '0) begin
         result.value = VALUE_BITS'(count_in);
      end else begin
         result.value = VALUE_BITS'(0) - VALUE_BITS'(number_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         number_ff <= '0;
      end else if (load_en) begin
         count_ff  <= COUNT_BITS'(load_value);
      end else if (accept) begin
         count_ff  <= count_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         number_ff <= number_in;
      end
   end

   a_number_bounded: assert property (@(posedge clock) disable iff (reset)
      number_ff <= NUM_FULL)
      else $error("waiter number above queue depth");

   a_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      (number_ff == '0 || number_ff == NUM_FULL) |-> head_ff == tail_ff)
      else $error("queue pointers disagree with waiter number");

   a_handoff_pops: assert property (@(posedge clock) disable iff (reset)
      (accept && !load_en && status == ST_HANDED) |=>
         number_ff == $past(number_ff) - NUM_BITS'(1))
      else $error("handoff did not remove a waiter");

   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      (!accept && !load_en) |=> $stable(count_ff) && $stable(number_ff))
      else $error("semaphore state moved without a transaction");

   a_queue_only_at_zero: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> count_ff == '0 && number_ff < NUM_FULL)
      else $error("thread queued while units were left");

endmodule

### tb/csfw_tb_pkg.sv
// semaphore mirror class that predicts and checks response transactions
package csfw_tb_pkg;
   import csfw_pkg::*;

   typedef struct {
      status_type                status;
      logic                      woken_valid;
      logic [THREAD_ID_BITS-1:0] woken_thread;
      logic [VALUE_BITS-1:0]     value;
   } outcome_type;

   class semaphore_mirror;
      logic [COUNT_BITS-1:0]     units;
      logic [THREAD_ID_BITS-1:0] waiter_ids [MAX_WAITERS];
      logic [PTR_BITS-1:0]       head;
      logic [PTR_BITS-1:0]       tail;
      logic [NUM_BITS-1:0]       waiting;
      outcome_type               awaited_outcomes[$];
      int                        mismatches;
      int                        status_seen [5];

      function new();
         units      = '0;
         head       = '0;
         tail       = '0;
         waiting    = '0;
         mismatches = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void load_count(logic [CFG_BITS-1:0] count);
         units = COUNT_BITS'(count);
      endfunction

      function int pending();
         return awaited_outcomes.size();
      endfunction

      // decide a take or release and queue its outcome
      function void note_request(logic kind, logic [THREAD_ID_BITS-1:0] tid);
         outcome_type o;
         o.woken_valid  = 1'b0;
         o.woken_thread = '0;
         if (kind == KIND_TAKE) begin
            if (units != '0) begin
               units    = units - 1'b1;
               o.status = ST_GRANTED;
            end else if (waiting == NUM_FULL) begin
               o.status = ST_REFUSED;
            end else begin
               waiter_ids[tail] = tid;
               tail     = (tail == PTR_LAST) ? '0 : tail + 1'b1;
               waiting  = waiting + 1'b1;
               o.status = ST_QUEUED;
            end
         end else begin
            if (waiting != '0) begin
               o.woken_valid  = 1'b1;
               o.woken_thread = waiter_ids[head];
               head     = (head == PTR_LAST) ? '0 : head + 1'b1;
               waiting  = waiting - 1'b1;
               o.status = ST_HANDED;
            end else if (units == '1) begin
               o.status = ST_REFUSED;
            end else begin
               units    = units + 1'b1;
               o.status = ST_RELEASED;
            end
         end
         o.value = (units != '0) ? VALUE_BITS'(units) : VALUE_BITS'(0) - VALUE_BITS'(waiting);
         awaited_outcomes.push_back(o);
      endfunction

      function void check_response(logic [2:0] status, logic woken_valid,
                                   logic [THREAD_ID_BITS-1:0] woken_thread,
                                   logic [VALUE_BITS-1:0] value);
         outcome_type o;
         if (awaited_outcomes.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatches++;
            return;
         end
         o = awaited_outcomes.pop_front();
         if (o.status < 5) status_seen[o.status]++;
         if (status !== o.status) begin
            $error("status expected %0d actual %0d", o.status, status);
            mismatches++;
         end
         if (woken_valid !== o.woken_valid) begin
            $error("woken_valid expected %0d actual %0d", o.woken_valid, woken_valid);
            mismatches++;
         end
         if (woken_thread !== o.woken_thread) begin
            $error("woken_thread expected %0d actual %0d", o.woken_thread, woken_thread);
            mismatches++;
         end
         if (value !== o.value) begin
            $error("value expected %0d actual %0d", $signed(o.value), $signed(value));
            mismatches++;
         end
      endfunction
   endclass
endpackage

### tb/testbench.sv
// testbench for the counting semaphore with fifo waiters
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import csfw_pkg::*;
   import csfw_tb_pkg::*;

   localparam int IDLE_LIMIT = 1000;    // cycles with no transaction before giving up
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 73;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_INITIAL_COUNT = {REG_INITIAL_COUNT, 2'b00};

   logic clock;
   logic reset = 1'b1;

   // request side, all driven to known values from time zero
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata  = '0;   // [7:0] thread_id
   logic                     req_tuser  = 1'b0; // [0] kind

   // response side
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [31:0]              rsp_tdata;         // [7:0] woken_thread, [24:8] value, [31:25] zero
   logic [3:0]               rsp_tuser;         // [2:0] status, [3] woken_valid

   // configuration port
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   semaphore_mirror mirror = new();

   int idle_cycles = 0;
   int requests_sent = 0;
   int count_loads = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   counting_semaphore_fifo_waiters u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request monitor: every accepted take or release updates the mirror
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         mirror.note_request(req_tuser, req_tdata);
      end
   end

   // response monitor: compare against the oldest outstanding outcome
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mirror.check_response(rsp_tuser[2:0], rsp_tuser[3], rsp_tdata[7:0],
                               rsp_tdata[8 +: VALUE_BITS]);
      end
   end

   // receiver backpressure: switches between always ready, mostly ready,
   // mostly stalled and a fixed on-off pattern taken from the mode counter
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         rx_mode_left <= 0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(20, 120);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= rx_mode_left[3];
         endcase
      end
   end

   // watchdog: a long stretch with no transaction on either side ends the run
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // one request transaction; returns at the edge where it is accepted and
   // leaves tvalid high so back-to-back calls keep the stream full
   task automatic send_request(input logic kind, input logic [7:0] tid);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= tid;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // hold off until every outstanding response has come back; the first
   // edge lets the monitor record the last accepted request before the
   // count is checked
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb write of initial_count; only called with the block drained
   task automatic load_initial_count(input logic [CFG_BITS-1:0] count);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_INITIAL_COUNT;
      csr_pwdata  <= CSR_DATA_BITS'(count);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register takes the value at this edge
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      mirror.load_count(count);
      count_loads++;
      @(posedge clock);
   endtask

   // random traffic in bursts with random gaps; take_pct steers the queue
   // toward full (many takes) or the count toward its maximum (many releases)
   task automatic random_phase(input int n, input int take_pct);
      int left_in_burst;
      int gap;
      left_in_burst = 0;
      for (int i = 0; i < n; i++) begin
         if (left_in_burst == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            left_in_burst = $urandom_range(1, 20);
         end
         send_request(($urandom_range(1, 100) <= take_pct) ? KIND_TAKE : KIND_RELEASE,
                      8'($urandom));
         left_in_burst--;
      end
   endtask

   initial begin
      logic [CFG_BITS-1:0] count;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // count zero after reset: take queues, release hands over, then the
      // count comes up and goes back down
      send_request(KIND_TAKE, 8'h00);
      send_request(KIND_RELEASE, 8'hff);
      send_request(KIND_RELEASE, 8'h5a);
      send_request(KIND_TAKE, 8'ha5);
      wait_drained();

      // count at its maximum: a release with no waiters is refused
      load_initial_count(16'hffff);
      send_request(KIND_RELEASE, 8'h01);
      send_request(KIND_TAKE, 8'h80);
      send_request(KIND_RELEASE, 8'h7f);
      wait_drained();

      // fill the waiter queue, the seventeenth take is refused
      load_initial_count(16'h0000);
      send_request(KIND_TAKE, 8'hff);
      send_request(KIND_TAKE, 8'h00);
      send_request(KIND_TAKE, 8'haa);
      send_request(KIND_TAKE, 8'h55);
      for (int i = 0; i < 13; i++) send_request(KIND_TAKE, 8'($urandom));
      wait_drained();

      // count loaded while threads wait: take granted, release still goes
      // to the oldest waiter and the count stays put
      load_initial_count(16'd5);
      send_request(KIND_TAKE, 8'h33);
      send_request(KIND_RELEASE, 8'hcc);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: count = '0;
            1: count = 16'd1;
            2: count = 16'hffff;
            3: count = 16'hfffe;
            4: count = CFG_BITS'($urandom_range(0, 20));
            default: count = CFG_BITS'($urandom);
         endcase
         load_initial_count(count);
         random_phase(PHASE_ITEMS, $urandom_range(20, 80));
         // sender sits idle until every response is back
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("covered %0d requests across %0d count loads", requests_sent, count_loads);
      $display("outcomes: granted %0d queued %0d released %0d handed %0d refused %0d",
               mirror.status_seen[ST_GRANTED], mirror.status_seen[ST_QUEUED],
               mirror.status_seen[ST_RELEASED], mirror.status_seen[ST_HANDED],
               mirror.status_seen[ST_REFUSED]);
      if (mirror.mismatches == 0 && mirror.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
